// ===== rtl/a2l_pkg.sv =====
// Package for the Annex B to length-prefix patcher.
// Holds the parser phase type, status codes, result record and constants.
// No dependencies.
package a2l_pkg;

    // Longest frame the counters are sized for
    localparam logic [32:0] FRAME_BYTES_MAX = 33'd16777216;
    localparam logic [32:0] CAP_WIDE        = FRAME_BYTES_MAX - 33'd1;

    // Position and body counters stop here
    localparam logic [23:0] COUNT_CAP =
        (CAP_WIDE < 33'h0FFFFFF) ? CAP_WIDE[23:0] : 24'hFFFFFF;

    // Start code detection
    localparam logic [31:0] RECENT_INIT = 32'hFFFFFFFF;
    localparam logic [23:0] SC3_PATTERN = 24'h000001;
    localparam logic [31:0] SC4_PATTERN = 32'h00000001;
    localparam logic [7:0]  BYTE_ZERO   = 8'h00;
    localparam logic [7:0]  BYTE_ONE    = 8'h01;
    localparam logic [23:0] SC4_BYTES   = 24'd4;
    localparam logic [23:0] SC3_BYTES   = 24'd3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_HEAD = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_SHORT_SC = 2'd3
    } status_t;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_HEAD0     = 7'b0000001,
        PH_HEAD1     = 7'b0000010,
        PH_HEAD2     = 7'b0000100,
        PH_HEAD3     = 7'b0001000,
        PH_BODY      = 7'b0010000,
        PH_ODD_FIRST = 7'b0100000,
        PH_ODD_LATER = 7'b1000000
    } phase_t;

    // One result record
    typedef struct packed {
        logic        patch_valid;
        logic [23:0] patch_offset;
        logic [23:0] patch_length;
        status_t     status;
        logic        frame_done;
    } res_t;

endpackage

// ===== rtl/annexb_to_length_prefix_patcher.sv =====
// Annex B to length-prefix patcher, one byte per cycle, one patch record out per unit.
// Top level: wires the byte parser to the result queue. Depends on a2l_pkg,
// a2l_step and a2l_outq.
//
// Feed a coded frame one byte per transfer, frame_last set on the final byte.
// Each byte is parsed in the cycle it is taken, so the block sustains one
// byte per clock; the only limit is the two-entry result queue, and in_ready
// falls whenever both entries are held, also while one leaves. Each result
// transfer is a patch record: offset of a 4-byte start code and the body
// length to write big-endian over it, or a frame_done record: ok for a frame
// of only a start code, else an error status (bad head, empty unit, 3-byte
// start code), then the frame's rest is dropped. Counters saturate at 0xFFFFFF.
module annexb_to_length_prefix_patcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        patch_valid,
    output logic [23:0] patch_offset,
    output logic [23:0] patch_length,
    output logic [1:0]  status,
    output logic        frame_done
);
    import a2l_pkg::*;

    logic  in_fire;
    logic  res_fire;
    res_t  res;
    res_t  out_data;

    assign in_fire = in_valid && in_ready;

    // Byte parser
    a2l_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .res_fire   (res_fire),
        .res        (res)
    );

    // Result register queue
    a2l_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_fire),
        .push_data (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign patch_valid  = out_data.patch_valid;
    assign patch_offset = out_data.patch_offset;
    assign patch_length = out_data.patch_length;
    assign status       = out_data.status;
    assign frame_done   = out_data.frame_done;

endmodule

// ===== rtl/a2l_step.sv =====
// Per-byte parser of the Annex B patcher: frame state registers and the
// combinational next-state and result logic. Depends on a2l_pkg.
module a2l_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [7:0]     data_byte,
    input  logic           frame_last,
    output logic           res_fire,
    output a2l_pkg::res_t  res
);
    import a2l_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        swallow_reg, swallow_next;
    logic [31:0] recent_reg, recent_next;
    logic [23:0] pos_reg, pos_next;
    logic [23:0] unit_off_reg, unit_off_next;
    logic [23:0] body_cnt_reg, body_cnt_next;

    logic [31:0] recent_shift;
    logic [23:0] body_inc;
    logic        odd;
    status_t     odd_code;
    logic        four;
    logic [23:0] cut;
    logic [23:0] size;
    logic [23:0] sc_off;
    logic        emit;

    // Shared body-byte terms
    always_comb
    begin
        recent_shift = {recent_reg[23:0], data_byte};
        body_inc     = (body_cnt_reg < COUNT_CAP) ? body_cnt_reg + 24'd1 : body_cnt_reg;
        odd          = (phase_reg != PH_BODY);
        odd_code     = (phase_reg == PH_ODD_FIRST) ? ST_BAD_HEAD : ST_SHORT_SC;
        four         = (recent_shift == SC4_PATTERN);
        cut          = four ? SC4_BYTES : SC3_BYTES;
        size         = (body_inc >= cut) ? body_inc - cut : 24'd0;
        sc_off       = (pos_reg >= 24'd3) ? pos_reg - 24'd3 : 24'd0;
    end

    // Next state and result for one accepted byte
    always_comb
    begin
        phase_next    = phase_reg;
        swallow_next  = swallow_reg;
        recent_next   = recent_reg;
        unit_off_next = unit_off_reg;
        body_cnt_next = body_cnt_reg;
        emit          = 1'b0;
        res           = '0;
        res.status    = ST_OK;

        if (frame_last)
            pos_next = 24'd0;
        else if (pos_reg < COUNT_CAP)
            pos_next = pos_reg + 24'd1;
        else
            pos_next = pos_reg;

        if (swallow_reg)
        begin
            // drop the rest of a failed frame
            if (frame_last)
            begin
                swallow_next = 1'b0;
                phase_next   = PH_HEAD0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HEAD0, PH_HEAD1:
                begin
                    if (data_byte != BYTE_ZERO || frame_last)
                    begin
                        emit           = 1'b1;
                        res.status     = ST_BAD_HEAD;
                        res.frame_done = 1'b1;
                        phase_next     = PH_HEAD0;
                        swallow_next   = !frame_last;
                    end
                    else
                        phase_next = (phase_reg == PH_HEAD0) ? PH_HEAD1 : PH_HEAD2;
                end
                PH_HEAD2:
                begin
                    if (data_byte == BYTE_ONE)
                    begin
                        if (frame_last)
                        begin
                            // frame holds only a start code
                            emit           = 1'b1;
                            res.frame_done = 1'b1;
                            phase_next     = PH_HEAD0;
                        end
                        else
                        begin
                            phase_next    = PH_ODD_FIRST;
                            unit_off_next = 24'd0;
                            body_cnt_next = 24'd0;
                            recent_next   = RECENT_INIT;
                        end
                    end
                    else if (data_byte != BYTE_ZERO || frame_last)
                    begin
                        emit           = 1'b1;
                        res.status     = ST_BAD_HEAD;
                        res.frame_done = 1'b1;
                        phase_next     = PH_HEAD0;
                        swallow_next   = !frame_last;
                    end
                    else
                        phase_next = PH_HEAD3;
                end
                PH_HEAD3:
                begin
                    if (data_byte != BYTE_ONE)
                    begin
                        emit           = 1'b1;
                        res.status     = ST_BAD_HEAD;
                        res.frame_done = 1'b1;
                        phase_next     = PH_HEAD0;
                        swallow_next   = !frame_last;
                    end
                    else if (frame_last)
                    begin
                        emit           = 1'b1;
                        res.frame_done = 1'b1;
                        phase_next     = PH_HEAD0;
                    end
                    else
                    begin
                        phase_next    = PH_BODY;
                        unit_off_next = 24'd0;
                        body_cnt_next = 24'd0;
                        recent_next   = RECENT_INIT;
                    end
                end
                PH_BODY, PH_ODD_FIRST, PH_ODD_LATER:
                begin
                    body_cnt_next = body_inc;
                    recent_next   = recent_shift;
                    if (frame_last)
                    begin
                        emit           = 1'b1;
                        res.frame_done = 1'b1;
                        phase_next     = PH_HEAD0;
                        if (odd)
                            res.status = odd_code;
                        else
                        begin
                            res.patch_valid  = 1'b1;
                            res.patch_offset = unit_off_reg;
                            res.patch_length = body_inc;
                        end
                    end
                    else if (recent_shift[23:0] == SC3_PATTERN)
                    begin
                        emit = 1'b1;
                        if (size == 24'd0 || odd)
                        begin
                            // empty unit or unit opened by a 3-byte code
                            res.status     = (size == 24'd0) ? ST_EMPTY : odd_code;
                            res.frame_done = 1'b1;
                            phase_next     = PH_HEAD0;
                            swallow_next   = 1'b1;
                        end
                        else
                        begin
                            res.patch_valid  = 1'b1;
                            res.patch_offset = unit_off_reg;
                            res.patch_length = size;
                            phase_next       = four ? PH_BODY : PH_ODD_LATER;
                            unit_off_next    = four ? sc_off : 24'd0;
                            body_cnt_next    = 24'd0;
                            recent_next      = RECENT_INIT;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEAD0;
                end
            endcase
        end
    end

    assign res_fire = in_fire && emit;

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD0;
            swallow_reg  <= 1'b0;
            recent_reg   <= RECENT_INIT;
            pos_reg      <= 24'd0;
            unit_off_reg <= 24'd0;
            body_cnt_reg <= 24'd0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            swallow_reg  <= swallow_next;
            recent_reg   <= recent_next;
            pos_reg      <= pos_next;
            unit_off_reg <= unit_off_next;
            body_cnt_reg <= body_cnt_next;
        end
    end

    // A failed or finished frame restarts at the head check
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && res.frame_done |=> phase_reg == PH_HEAD0)
        else $error("frame end result did not return to head check");

    // Nothing comes out while a failed frame is dropped
    a_swallow_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        swallow_reg |-> !res_fire)
        else $error("result while dropping a failed frame");

    // A patch record always carries ok status, an error always ends the frame
    a_patch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> (res.patch_valid ? res.status == ST_OK
                                      : res.frame_done))
        else $error("inconsistent result record");

endmodule

// ===== rtl/a2l_outq.sv =====
// Two-entry result register queue for the Annex B patcher; decouples
// the output handshake from byte intake. Depends on a2l_pkg.
module a2l_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  a2l_pkg::res_t  push_data,
    output logic           space,
    output logic           out_valid,
    input  logic           out_ready,
    output a2l_pkg::res_t  out_data
);
    import a2l_pkg::*;

    res_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Never written while full unless an entry leaves in the same cycle
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space || pop)
        else $error("result queue overflow");

    // Count tracks the pointers
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("result queue pointers out of step");

endmodule

// ===== tb/patch_record_checker.sv =====
// Checker for the Annex B to length-prefix patcher: watches both channels,
// predicts each result record from the accepted bytes and compares it field by field.
// Depends on a2l_pkg for the status, phase and record types.
module patch_record_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        patch_valid,
    input  logic [23:0] patch_offset,
    input  logic [23:0] patch_length,
    input  logic [1:0]  status,
    input  logic        frame_done,
    output int          mismatches,
    output int          expected_left,
    output int          results_seen,
    output int          patches_seen,
    output int          errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import a2l_pkg::*;

    // Predicted parser state
    logic [31:0] shift_bytes;
    logic [23:0] byte_pos;
    logic [23:0] unit_start;
    logic [23:0] body_len;
    phase_t      parse_phase;
    logic        dropping;

    res_t        pending_records[$];
    res_t        want_rec;
    res_t        seen_rec;
    res_t        new_rec;
    logic        has_rec;

    function automatic res_t make_record(logic valid, logic [23:0] off, logic [23:0] len,
                                         status_t st, logic done);
        res_t r;
        r.patch_valid  = valid;
        r.patch_offset = off;
        r.patch_length = len;
        r.status       = st;
        r.frame_done   = done;
        return r;
    endfunction

    // Error ends the frame; remaining bytes are dropped unless this was the last one
    function automatic res_t abort_frame(status_t st, logic last);
        parse_phase = PH_HEAD0;
        dropping    = !last;
        return make_record(1'b0, 24'd0, 24'd0, st, 1'b1);
    endfunction

    function automatic void start_body(phase_t next, logic [23:0] off);
        parse_phase = next;
        unit_start  = off;
        body_len    = 24'd0;
        shift_bytes = RECENT_INIT;
    endfunction

    // Advance the predicted parser by one byte
    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output logic got, output res_t r);
        logic [23:0] pos;
        logic        odd;
        status_t     code;
        logic        four;
        logic [23:0] cut;
        logic [23:0] size;
        begin
            got = 1'b0;
            r   = '0;
            pos = byte_pos;
            if (last)
                byte_pos = 24'd0;
            else if (byte_pos < COUNT_CAP)
                byte_pos = byte_pos + 24'd1;

            if (dropping) begin
                if (last) begin
                    dropping    = 1'b0;
                    parse_phase = PH_HEAD0;
                end
            end else begin
                case (parse_phase)
                    PH_HEAD0, PH_HEAD1: begin
                        if (b != BYTE_ZERO || last) begin
                            r   = abort_frame(ST_BAD_HEAD, last);
                            got = 1'b1;
                        end else begin
                            parse_phase = (parse_phase == PH_HEAD0) ? PH_HEAD1 : PH_HEAD2;
                        end
                    end
                    PH_HEAD2: begin
                        if (b == BYTE_ONE) begin
                            if (last) begin
                                r           = make_record(1'b0, 24'd0, 24'd0, ST_OK, 1'b1);
                                got         = 1'b1;
                                parse_phase = PH_HEAD0;
                            end else begin
                                start_body(PH_ODD_FIRST, 24'd0);
                            end
                        end else if (b != BYTE_ZERO || last) begin
                            r   = abort_frame(ST_BAD_HEAD, last);
                            got = 1'b1;
                        end else begin
                            parse_phase = PH_HEAD3;
                        end
                    end
                    PH_HEAD3: begin
                        if (b != BYTE_ONE) begin
                            r   = abort_frame(ST_BAD_HEAD, last);
                            got = 1'b1;
                        end else if (last) begin
                            r           = make_record(1'b0, 24'd0, 24'd0, ST_OK, 1'b1);
                            got         = 1'b1;
                            parse_phase = PH_HEAD0;
                        end else begin
                            start_body(PH_BODY, 24'd0);
                        end
                    end
                    default: begin
                        // Body byte: unit after a 3-byte code is only tracked to its end
                        odd  = (parse_phase != PH_BODY);
                        code = (parse_phase == PH_ODD_FIRST) ? ST_BAD_HEAD : ST_SHORT_SC;
                        if (body_len < COUNT_CAP)
                            body_len = body_len + 24'd1;
                        shift_bytes = {shift_bytes[23:0], b};
                        if (last) begin
                            got = 1'b1;
                            if (odd) begin
                                r = abort_frame(code, 1'b1);
                            end else begin
                                r = make_record(1'b1, unit_start, body_len, ST_OK, 1'b1);
                                parse_phase = PH_HEAD0;
                            end
                        end else if (shift_bytes[23:0] == SC3_PATTERN) begin
                            got  = 1'b1;
                            four = (shift_bytes == SC4_PATTERN);
                            cut  = four ? SC4_BYTES : SC3_BYTES;
                            size = (body_len >= cut) ? body_len - cut : 24'd0;
                            if (size == 24'd0) begin
                                r = abort_frame(ST_EMPTY, 1'b0);
                            end else if (odd) begin
                                r = abort_frame(code, 1'b0);
                            end else begin
                                r = make_record(1'b1, unit_start, size, ST_OK, 1'b0);
                                if (four)
                                    start_body(PH_BODY, (pos >= 24'd3) ? pos - 24'd3 : 24'd0);
                                else
                                    start_body(PH_ODD_LATER, 24'd0);
                            end
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic report_mismatch(input string what, input res_t want, input res_t got);
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display({"%0t mismatch (%s) on result %0d: ",
                          "expected v=%0b off=%06h len=%06h st=%0d done=%0b, ",
                          "got v=%0b off=%06h len=%06h st=%0d done=%0b"},
                         $realtime, what, results_seen,
                         want.patch_valid, want.patch_offset, want.patch_length,
                         want.status, want.frame_done,
                         got.patch_valid, got.patch_offset, got.patch_length,
                         got.status, got.frame_done);
        end
    endtask

    // Compare finished results first, then predict from the byte taken on this edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shift_bytes   <= RECENT_INIT;
            byte_pos      <= 24'd0;
            unit_start    <= 24'd0;
            body_len      <= 24'd0;
            parse_phase   <= PH_HEAD0;
            dropping      <= 1'b0;
            pending_records.delete();
            mismatches    <= 0;
            expected_left <= 0;
            results_seen  <= 0;
            patches_seen  <= 0;
            errors_seen   <= 0;
        end else begin
            if (out_valid && out_ready) begin
                seen_rec = make_record(patch_valid, patch_offset, patch_length,
                                       status_t'(status), frame_done);
                if (pending_records.size() == 0) begin
                    report_mismatch("unexpected", '0, seen_rec);
                end else begin
                    want_rec = pending_records.pop_front();
                    if (seen_rec.patch_valid !== want_rec.patch_valid)
                        report_mismatch("patch_valid", want_rec, seen_rec);
                    else if (seen_rec.patch_offset !== want_rec.patch_offset)
                        report_mismatch("patch_offset", want_rec, seen_rec);
                    else if (seen_rec.patch_length !== want_rec.patch_length)
                        report_mismatch("patch_length", want_rec, seen_rec);
                    else if (seen_rec.status !== want_rec.status)
                        report_mismatch("status", want_rec, seen_rec);
                    else if (seen_rec.frame_done !== want_rec.frame_done)
                        report_mismatch("frame_done", want_rec, seen_rec);
                    if (want_rec.patch_valid)
                        patches_seen = patches_seen + 1;
                    if (want_rec.status != ST_OK)
                        errors_seen = errors_seen + 1;
                end
                results_seen = results_seen + 1;
            end
            if (in_valid && in_ready) begin
                parse_byte(data_byte, frame_last, has_rec, new_rec);
                if (has_rec)
                    pending_records.push_back(new_rec);
            end
            expected_left = pending_records.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the patcher testbench: clock, reset, frame stimulus and the verdict.
// Depends on a2l_pkg, the patcher RTL and patch_record_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT   = 200000;
    localparam int TOTAL_BYTES  = 550;
    localparam int DRAIN_CYCLES = 16;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        patch_valid;
    logic [23:0] patch_offset;
    logic [23:0] patch_length;
    logic [1:0]  status;
    logic        frame_done;

    int          mismatches;
    int          expected_left;
    int          results_seen;
    int          patches_seen;
    int          errors_seen;

    int          cycles = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_tick = 0;
    logic [7:0]  frame_q[$];

    always #5 clk = ~clk;

    annexb_to_length_prefix_patcher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .patch_valid  (patch_valid),
        .patch_offset (patch_offset),
        .patch_length (patch_length),
        .status       (status),
        .frame_done   (frame_done)
    );

    patch_record_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .frame_last    (frame_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .patch_valid   (patch_valid),
        .patch_offset  (patch_offset),
        .patch_length  (patch_length),
        .status        (status),
        .frame_done    (frame_done),
        .mismatches    (mismatches),
        .expected_left (expected_left),
        .results_seen  (results_seen),
        .patches_seen  (patches_seen),
        .errors_seen   (errors_seen)
    );

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, expected_left);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: stall mode switches at random (always ready, random, long stalls)
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            stall_tick = stall_tick + 1;
            if (stall_tick % 64 == 0)
                stall_mode = int'($urandom_range(0, 2));
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= (stall_tick % 12) >= 9;
            endcase
        end
    end

    // Zero-biased bytes (a quarter forced to zero) so that accidental start codes show up inside bodies
    function automatic logic [7:0] body_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_start_code(input int n);
        begin
            repeat (n - 1) frame_q.push_back(8'h00);
            frame_q.push_back(8'h01);
        end
    endtask

    // One frame: mostly well formed with random content, the rest broken or noise
    task automatic build_random_frame();
        int kind;
        int nunits;
        int len;
        int sep;
        begin
            frame_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                push_start_code(4);
                nunits = $urandom_range(1, 4);
                for (int u = 0; u < nunits; u++) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48)
                                                     : $urandom_range(1, 8);
                    repeat (len) frame_q.push_back(body_byte());
                    if (u < nunits - 1) begin
                        sep = $urandom_range(0, 99);
                        if (sep < 85) begin
                            push_start_code(4);
                        end else if (sep < 93) begin
                            push_start_code(3);
                        end else begin
                            // empty unit
                            push_start_code(4);
                            push_start_code(4);
                        end
                    end
                end
                // start code on the final byte belongs to the body
                if ($urandom_range(0, 9) == 0)
                    push_start_code($urandom_range(3, 4));
            end else if (kind < 80) begin
                push_start_code(3);
                len = $urandom_range(1, 8);
                repeat (len) frame_q.push_back(body_byte());
                if ($urandom_range(0, 1) == 0) begin
                    push_start_code(4);
                    frame_q.push_back(body_byte());
                end
            end else if (kind < 90) begin
                push_start_code(4);
                frame_q[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
                len = $urandom_range(0, 6);
                repeat (len) frame_q.push_back(body_byte());
            end else begin
                len = $urandom_range(1, 12);
                repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Send frame_q byte by byte in bursts; some frames go without gaps
    task automatic send_frame();
        logic calm;
        begin
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < frame_q.size(); i++) begin
                if (burst_left == 0) begin
                    if (!calm) begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 20);
                end
                burst_left = burst_left - 1;
                in_valid   <= 1'b1;
                data_byte  <= frame_q[i];
                frame_last <= (i == frame_q.size() - 1);
                @(posedge clk);
                while (!in_ready) @(posedge clk);
                bytes_sent = bytes_sent + 1;
            end
            frames_sent = frames_sent + 1;
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h01};           // head only, no unit
        send_frame();
        frame_q = '{8'h00, 8'h00, 8'h01};                  // short head only
        send_frame();
        frame_q = '{8'hFF};                                // bad head on the final byte
        send_frame();
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,     // patch, then 3-byte code
                    8'h00, 8'h00, 8'h01, 8'h80};
        send_frame();
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00,     // empty unit, tail dropped
                    8'h00, 8'h00, 8'h01, 8'h7F};
        send_frame();
        frame_q = '{8'h00, 8'h00, 8'h01, 8'hAA, 8'hFF};    // short head with a body
        send_frame();
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00,     // start code on final byte
                    8'h00, 8'h01};
        send_frame();

        // Random frames
        while (bytes_sent < TOTAL_BYTES) begin
            build_random_frame();
            send_frame();
        end
        in_valid <= 1'b0;

        // Drain
        while (expected_left != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("sent %0d bytes in %0d frames; checked %0d results", bytes_sent,
                 frames_sent, results_seen);
        $display("  %0d patch records, %0d error records, %0d mismatches", patches_seen,
                 errors_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
